@@ rtl/rcs_pkg.sv @@
package rcs_pkg;

  // Field widths
  localparam int SEQ_W  = 31;
  localparam int LEN_W  = 12;
  localparam int ULEN_W = 11;
  localparam int HDR_W  = 32;

  // Fixed byte overheads taken off the packet room
  localparam int HEADER_BYTES = 8;
  localparam int PACKET_SLACK = 16;

  // Width of the room arithmetic (capacities stay below 2^16)
  localparam int ROOM_W = 17;

  typedef enum logic {
    CMD_TRANSMIT = 1'b0,
    CMD_RECEIVE  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_SENT     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_STALE    = 2'd3
  } status_t;

  typedef struct packed {
    command_t                  command;
    logic [LEN_W-1:0]          queued_message_size;
    logic                      queued_overflowed;
    logic [ULEN_W-1:0]         unreliable_length;
    logic [HDR_W-1:0]          rx_header_first;
    logic [HDR_W-1:0]          rx_header_second;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [HDR_W-1:0]          tx_header_first;
    logic [HDR_W-1:0]          tx_header_second;
    logic                      reliable_included;
    logic [LEN_W-1:0]          reliable_payload_length;
    logic                      message_latched;
    logic                      unreliable_fits;
    logic [SEQ_W-1:0]          dropped_packets;
    logic                      can_send_reliable;
  } result_t;

  // Channel state held between items
  typedef struct packed {
    logic [SEQ_W-1:0]          out_seq;
    logic [SEQ_W-1:0]          in_seq;
    logic                      in_reliable_bit;
    logic [SEQ_W-1:0]          in_acked_seq;
    logic                      in_acked_reliable_bit;
    logic                      reliable_bit;
    logic [SEQ_W-1:0]          last_reliable_seq;
    logic [LEN_W-1:0]          reliable_len;
  } chan_state_t;

  localparam chan_state_t STATE_RESET = '{
    out_seq:               SEQ_W'(1),
    in_seq:                '0,
    in_reliable_bit:       1'b0,
    in_acked_seq:          '0,
    in_acked_reliable_bit: 1'b0,
    reliable_bit:          1'b0,
    last_reliable_seq:     '0,
    reliable_len:          '0
  };

endpackage

@@ rtl/rcs_channels.sv @@
// Input channel: header request items
interface rcs_in_if;
  logic                          valid;
  logic                          ready;
  rcs_pkg::command_t             command;
  logic [rcs_pkg::LEN_W-1:0]     queued_message_size;
  logic                          queued_overflowed;
  logic [rcs_pkg::ULEN_W-1:0]    unreliable_length;
  logic [rcs_pkg::HDR_W-1:0]     rx_header_first;
  logic [rcs_pkg::HDR_W-1:0]     rx_header_second;

  modport source (
    output valid, command, queued_message_size, queued_overflowed,
           unreliable_length, rx_header_first, rx_header_second,
    input  ready
  );
  modport sink (
    input  valid, command, queued_message_size, queued_overflowed,
           unreliable_length, rx_header_first, rx_header_second,
    output ready
  );
endinterface

// Output channel: result items
interface rcs_out_if;
  logic                          valid;
  logic                          ready;
  rcs_pkg::status_t              status;
  logic [rcs_pkg::HDR_W-1:0]     tx_header_first;
  logic [rcs_pkg::HDR_W-1:0]     tx_header_second;
  logic                          reliable_included;
  logic [rcs_pkg::LEN_W-1:0]     reliable_payload_length;
  logic                          message_latched;
  logic                          unreliable_fits;
  logic [rcs_pkg::SEQ_W-1:0]     dropped_packets;
  logic                          can_send_reliable;

  modport source (
    output valid, status, tx_header_first, tx_header_second, reliable_included,
           reliable_payload_length, message_latched, unreliable_fits,
           dropped_packets, can_send_reliable,
    input  ready
  );
  modport sink (
    input  valid, status, tx_header_first, tx_header_second, reliable_included,
           reliable_payload_length, message_latched, unreliable_fits,
           dropped_packets, can_send_reliable,
    output ready
  );
endinterface

@@ rtl/rcs_core.sv @@
// Header logic for one item: next channel state and the result item
module rcs_core #(
  parameter int MSG_CAPACITY    = 2048,
  parameter int PACKET_CAPACITY = 1400
) (
  input  rcs_pkg::in_item_t    item,
  input  rcs_pkg::chan_state_t st,
  output rcs_pkg::chan_state_t st_next,
  output rcs_pkg::result_t     result
);

  localparam int ROOM = PACKET_CAPACITY - rcs_pkg::PACKET_SLACK - rcs_pkg::HEADER_BYTES;
  localparam logic [rcs_pkg::ROOM_W-1:0] ROOM_V = rcs_pkg::ROOM_W'(ROOM);
  localparam logic [rcs_pkg::ROOM_W-1:0] CAP_V  = rcs_pkg::ROOM_W'(MSG_CAPACITY);

  logic                          resend;
  logic                          latched;
  logic                          send;
  logic [rcs_pkg::LEN_W-1:0]     cap_len;
  logic [rcs_pkg::LEN_W-1:0]     tx_len;
  logic [rcs_pkg::ROOM_W-1:0]    need;
  logic [rcs_pkg::SEQ_W-1:0]     out_seq_inc;
  logic [rcs_pkg::SEQ_W-1:0]     rx_seq;
  logic [rcs_pkg::SEQ_W-1:0]     rx_ack;
  logic                          rx_rel;
  logic                          rx_rel_ack;
  logic                          stale;

  // Transmit decisions
  assign resend  = (st.in_acked_seq > st.last_reliable_seq) &&
                   (st.in_acked_reliable_bit != st.reliable_bit);
  assign latched = (st.reliable_len == '0) && (item.queued_message_size != '0);
  assign send    = resend || latched;

  // Saturate the queued size to the message capacity
  assign cap_len = (rcs_pkg::ROOM_W'(item.queued_message_size) > CAP_V) ?
                   CAP_V[rcs_pkg::LEN_W-1:0] : item.queued_message_size;
  assign tx_len  = latched ? cap_len : st.reliable_len;

  // Unreliable part plus included reliable payload against packet room
  assign need = rcs_pkg::ROOM_W'(item.unreliable_length) +
                (send ? rcs_pkg::ROOM_W'(tx_len) : '0);

  assign out_seq_inc = st.out_seq + rcs_pkg::SEQ_W'(1);

  // Receive header fields
  assign rx_seq     = item.rx_header_first[rcs_pkg::SEQ_W-1:0];
  assign rx_rel     = item.rx_header_first[rcs_pkg::HDR_W-1];
  assign rx_ack     = item.rx_header_second[rcs_pkg::SEQ_W-1:0];
  assign rx_rel_ack = item.rx_header_second[rcs_pkg::HDR_W-1];
  assign stale      = (rx_seq <= st.in_seq);

  always_comb begin
    st_next = st;
    result  = '0;
    result.status = rcs_pkg::ST_SENT;
    if (item.command == rcs_pkg::CMD_RECEIVE) begin
      if (stale) begin
        result.status = rcs_pkg::ST_STALE;
      end else begin
        result.status          = rcs_pkg::ST_ACCEPTED;
        result.dropped_packets = rx_seq - st.in_seq - rcs_pkg::SEQ_W'(1);
        if (rx_rel_ack == st.reliable_bit) begin
          st_next.reliable_len = '0;
        end
        st_next.in_seq                = rx_seq;
        st_next.in_acked_seq          = rx_ack;
        st_next.in_acked_reliable_bit = rx_rel_ack;
        st_next.in_reliable_bit       = st.in_reliable_bit ^ rx_rel;
      end
    end else if (item.queued_overflowed) begin
      result.status = rcs_pkg::ST_OVERFLOW;
    end else begin
      result.tx_header_first   = {send, st.out_seq};
      result.tx_header_second  = {st.in_reliable_bit, st.in_seq};
      result.reliable_included = send;
      result.message_latched   = latched;
      result.unreliable_fits   = (need <= ROOM_V);
      st_next.out_seq          = out_seq_inc;
      st_next.reliable_len     = tx_len;
      if (latched) begin
        st_next.reliable_bit = ~st.reliable_bit;
      end
      if (send) begin
        st_next.last_reliable_seq = out_seq_inc;
      end
    end
    // Common fields report the state after the step
    result.reliable_payload_length = st_next.reliable_len;
    result.can_send_reliable       = (st_next.reliable_len == '0);
  end

endmodule

@@ rtl/reliable_channel_sequencer.sv @@
// Reliable channel sequencer: header engine of a sequenced datagram channel
// with one alternating-bit reliable message.
// Channels: in_ch carries request items (command 0 builds an outgoing header,
// command 1 processes a received header); out_ch carries one result item per
// request. Both use valid/ready; an item moves when both are high.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one item per cycle while out_ch is not stalled. Channel state is
// updated at the accepting edge, so the next item sees it at once; the header
// logic between the state registers and the result register is combinational.
// Reset (rst, synchronous): out_seq returns to 1, all other sequence, bit and
// length state clears, and the result register empties.
// Receiver stall: the result register holds its item; a new request is
// still taken in the cycle the pending result is taken (in_ch.ready follows
// out_ch.ready), otherwise in_ch.ready stays low until the stall ends.
module reliable_channel_sequencer #(
  parameter int MSG_CAPACITY    = 2048,
  parameter int PACKET_CAPACITY = 1400
) (
  input  logic       clk,
  input  logic       rst,
  rcs_in_if.sink     in_ch,
  rcs_out_if.source  out_ch
);

  rcs_pkg::in_item_t    item;
  rcs_pkg::chan_state_t st;
  rcs_pkg::chan_state_t st_next;
  rcs_pkg::result_t     result_next;
  rcs_pkg::result_t     result;
  logic                 out_valid;
  logic                 accept;

  assign item = '{
    command:             in_ch.command,
    queued_message_size: in_ch.queued_message_size,
    queued_overflowed:   in_ch.queued_overflowed,
    unreliable_length:   in_ch.unreliable_length,
    rx_header_first:     in_ch.rx_header_first,
    rx_header_second:    in_ch.rx_header_second
  };

  rcs_core #(
    .MSG_CAPACITY    (MSG_CAPACITY),
    .PACKET_CAPACITY (PACKET_CAPACITY)
  ) u_core (
    .item    (item),
    .st      (st),
    .st_next (st_next),
    .result  (result_next)
  );

  // Take a new item whenever the result register is free or being emptied
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rcs_pkg::STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign out_ch.valid                   = out_valid;
  assign out_ch.status                  = result.status;
  assign out_ch.tx_header_first         = result.tx_header_first;
  assign out_ch.tx_header_second        = result.tx_header_second;
  assign out_ch.reliable_included       = result.reliable_included;
  assign out_ch.reliable_payload_length = result.reliable_payload_length;
  assign out_ch.message_latched         = result.message_latched;
  assign out_ch.unreliable_fits         = result.unreliable_fits;
  assign out_ch.dropped_packets         = result.dropped_packets;
  assign out_ch.can_send_reliable       = result.can_send_reliable;

endmodule
